@@ rtl/core/ocl_pkg.sv @@
// Shared types and constants of the ordered card list.
// Used by the channel interfaces, the card store and the top level; no dependencies.
package ocl_pkg;

   // Field widths of the request and response transactions.
   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 4;
   localparam int SUIT_W   = 2;
   localparam int POS_W    = 7;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int FPOS_W   = 6;
   localparam int HELD_W   = 7;

   // Deck geometry and limits.
   localparam int NUM_SUITS     = 4;
   localparam int NUM_RANKS     = 13;
   localparam int DECK_SIZE     = NUM_SUITS * NUM_RANKS;
   localparam int MAX_TAKE      = 64;
   localparam int DEFAULT_DEPTH = 64;

   // Command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 3'd0,
      CMD_SEARCH = 3'd1,
      CMD_READ   = 3'd2,
      CMD_REMOVE = 3'd3,
      CMD_TAKE   = 3'd4,
      CMD_LOAD   = 3'd5
   } cmd_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_TOO_FEW   = 2'd3
   } status_type;

   // One stored card: suit in the upper bits, rank in the lower bits.
   typedef struct packed {
      logic [SUIT_W-1:0]  suit;
      logic [VALUE_W-1:0] value;
   } card_type;

endpackage

@@ rtl/core/ocl_req_if.sv @@
// Request channel of the ordered card list: valid/ready handshake plus command payload.
// Depends on ocl_pkg for the field widths.
interface ocl_req_if;

   logic                              valid;
   logic                              ready;
   logic [ocl_pkg::CMD_W-1:0]         cmd;
   logic [ocl_pkg::VALUE_W-1:0]       card_value;
   logic [ocl_pkg::SUIT_W-1:0]        card_suit;
   logic signed [ocl_pkg::POS_W-1:0]  position;
   logic [ocl_pkg::COUNT_W-1:0]       count;

   modport source (
      output valid, cmd, card_value, card_suit, position, count,
      input  ready
   );

   modport sink (
      input  valid, cmd, card_value, card_suit, position, count,
      output ready
   );

endinterface

@@ rtl/core/ocl_rsp_if.sv @@
// Response channel of the ordered card list: valid/ready handshake plus result payload.
// Depends on ocl_pkg for the field widths.
interface ocl_rsp_if;

   logic                           valid;
   logic                           ready;
   logic [ocl_pkg::STATUS_W-1:0]   status;
   logic [ocl_pkg::VALUE_W-1:0]    out_value;
   logic [ocl_pkg::SUIT_W-1:0]     out_suit;
   logic [ocl_pkg::FPOS_W-1:0]     found_position;
   logic [ocl_pkg::HELD_W-1:0]     held_count;
   logic                           last;

   modport source (
      output valid, status, out_value, out_suit, found_position, held_count, last,
      input  ready
   );

   modport sink (
      input  valid, status, out_value, out_suit, found_position, held_count, last,
      output ready
   );

endinterface

@@ rtl/core/ocl_card_store.sv @@
// Card memory of the ordered card list: one write port and one registered read port.
// Depends on ocl_pkg for the card type.
module ocl_card_store #(
   parameter int DEPTH = ocl_pkg::DEFAULT_DEPTH
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  ocl_pkg::card_type            wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output ocl_pkg::card_type            rd_data
);

   ocl_pkg::card_type mem [DEPTH];
   ocl_pkg::card_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data register holds its value until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ordered_card_list.sv @@
// Ordered card list: keeps up to DEPTH cards (rank, suit) in order with a fill count and runs
// one command per request transaction under a small sequencer around a card memory that does
// one read and one write per cycle. No request is taken while a command is in progress.
// Each command is latched on acceptance and checked; append and any refused command then reply,
// read reads the resolved position, search reads and compares one card at a time, remove moves
// the cards behind the removed position down by one, take front delivers the front cards one
// response each (waiting while the response side stalls) and then moves the remaining cards to
// the front, and loading a deck writes the 52 cards one after another before the reply.
// The card memory needs no clearing pass after reset; only the fill count, the state and the
// read and response valid flags are reset.
// Depends on ocl_pkg, ocl_req_if, ocl_rsp_if and ocl_card_store.
module ordered_card_list #(
   parameter int DEPTH = ocl_pkg::DEFAULT_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   ocl_req_if.sink    req_if,
   ocl_rsp_if.source  rsp_if
);

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam int CW = ((FW > ocl_pkg::POS_W) ? FW : ocl_pkg::POS_W) + 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_SEARCH,
      S_READ,
      S_SHIFT,
      S_TAKE_RD,
      S_TAKE_WAIT,
      S_LOAD,
      S_REPLY
   } state_type;

   // Sequencer state and latched request.
   state_type                          state_ff, state_in;
   ocl_pkg::cmd_type                   cmd_ff, cmd_in;
   ocl_pkg::card_type                  card_ff, card_in;
   logic signed [ocl_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [ocl_pkg::COUNT_W-1:0]        count_ff, count_in;

   // List bookkeeping and loop counters.
   logic [FW-1:0]                      fill_ff, fill_in;
   logic [FW-1:0]                      scan_ff, scan_in;
   logic [FW-1:0]                      end_ff, end_in;
   logic [FW-1:0]                      off_ff, off_in;
   logic                               rd_vld_ff, rd_vld_in;
   logic [AW-1:0]                      wr_addr_ff, wr_addr_in;
   logic [ocl_pkg::VALUE_W-1:0]        rank_ff, rank_in;
   logic [ocl_pkg::SUIT_W-1:0]         suit_ff, suit_in;

   // Pending single response.
   ocl_pkg::status_type                rep_status_ff, rep_status_in;
   ocl_pkg::card_type                  rep_card_ff, rep_card_in;
   logic [ocl_pkg::FPOS_W-1:0]         rep_fpos_ff, rep_fpos_in;

   // Response output register.
   logic                               rsp_valid_ff, rsp_valid_in;
   ocl_pkg::status_type                rsp_status_ff, rsp_status_in;
   ocl_pkg::card_type                  rsp_card_ff, rsp_card_in;
   logic [ocl_pkg::FPOS_W-1:0]         rsp_fpos_ff, rsp_fpos_in;
   logic [ocl_pkg::HELD_W-1:0]         rsp_held_ff, rsp_held_in;
   logic                               rsp_last_ff, rsp_last_in;

   // Card memory ports.
   logic                               mem_wr_en;
   logic [AW-1:0]                      mem_wr_addr;
   ocl_pkg::card_type                  mem_wr_data;
   logic                               mem_rd_en;
   logic [AW-1:0]                      mem_rd_addr;
   ocl_pkg::card_type                  mem_rd_data;

   // Arithmetic helpers.
   logic                               req_accept;
   logic                               rsp_free;
   logic [CW-1:0]                      fill_ext;
   logic [CW-1:0]                      pos_ext;
   logic [CW-1:0]                      mag_ext;
   logic [CW-1:0]                      idx_ext;
   logic [CW-1:0]                      n_ext;
   logic                               pos_ok;
   logic                               n_bad;
   logic                               search_hit;
   logic                               take_last;
   logic [FW-1:0]                      hit_pos;

   ocl_card_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_accept = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == S_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   // Position resolution: a negative position counts back from the fill count.
   // The magnitude is taken unsigned so that the most negative position reads as 64.
   assign fill_ext = CW'(fill_ff);
   assign pos_ext  = CW'(unsigned'(pos_ff));
   assign mag_ext  = CW'(unsigned'(ocl_pkg::POS_W'(-pos_ff)));
   assign pos_ok   = pos_ff[ocl_pkg::POS_W-1] ? (fill_ext >= mag_ext) : (pos_ext < fill_ext);
   assign idx_ext  = pos_ff[ocl_pkg::POS_W-1] ? (fill_ext - mag_ext) : pos_ext;

   // Take front bounds and loop end.
   assign n_ext     = CW'(count_ff);
   assign n_bad     = (n_ext > fill_ext) || (n_ext > CW'(ocl_pkg::MAX_TAKE));
   assign take_last = ((CW'(scan_ff) + CW'(1)) == n_ext);

   // Search compare against the card read in the previous cycle.
   assign search_hit = rd_vld_ff && (mem_rd_data == card_ff);
   assign hit_pos    = scan_ff - FW'(1);

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      card_in       = card_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      fill_in       = fill_ff;
      scan_in       = scan_ff;
      end_in        = end_ff;
      off_in        = off_ff;
      rd_vld_in     = rd_vld_ff;
      wr_addr_in    = wr_addr_ff;
      rank_in       = rank_ff;
      suit_in       = suit_ff;
      rep_status_in = rep_status_ff;
      rep_card_in   = rep_card_ff;
      rep_fpos_in   = rep_fpos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_card_in   = rsp_card_ff;
      rsp_fpos_in   = rsp_fpos_ff;
      rsp_held_in   = rsp_held_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = fill_ff[AW-1:0];
      mem_wr_data   = card_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = scan_ff[AW-1:0];

      case (state_ff)
         // Latch the request transaction.
         S_IDLE: begin
            if (req_accept) begin
               cmd_in   = ocl_pkg::cmd_type'(req_if.cmd);
               card_in  = '{suit: req_if.card_suit, value: req_if.card_value};
               pos_in   = req_if.position;
               count_in = req_if.count;
               state_in = S_EXEC;
            end
         end

         // Check bounds and start the command.
         S_EXEC: begin
            rep_status_in = ocl_pkg::STATUS_OK;
            rep_card_in   = '0;
            rep_fpos_in   = '0;
            state_in      = S_REPLY;
            case (cmd_ff)
               ocl_pkg::CMD_APPEND: begin
                  if (fill_ext >= CW'(DEPTH)) begin
                     rep_status_in = ocl_pkg::STATUS_FULL;
                  end else begin
                     mem_wr_en = 1'b1;
                     fill_in   = fill_ff + FW'(1);
                  end
               end
               ocl_pkg::CMD_SEARCH: begin
                  scan_in   = '0;
                  rd_vld_in = 1'b0;
                  state_in  = S_SEARCH;
               end
               ocl_pkg::CMD_READ: begin
                  if (!pos_ok) begin
                     rep_status_in = ocl_pkg::STATUS_NOT_FOUND;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = idx_ext[AW-1:0];
                     state_in    = S_READ;
                  end
               end
               ocl_pkg::CMD_REMOVE: begin
                  if (!pos_ok) begin
                     rep_status_in = ocl_pkg::STATUS_NOT_FOUND;
                  end else begin
                     fill_in   = fill_ff - FW'(1);
                     scan_in   = FW'(idx_ext + CW'(1));
                     off_in    = FW'(1);
                     end_in    = fill_ff;
                     rd_vld_in = 1'b0;
                     state_in  = S_SHIFT;
                  end
               end
               ocl_pkg::CMD_TAKE: begin
                  if (count_ff == '0) begin
                     state_in = S_IDLE;
                  end else if (n_bad) begin
                     rep_status_in = ocl_pkg::STATUS_TOO_FEW;
                  end else begin
                     fill_in  = FW'(fill_ext - n_ext);
                     end_in   = fill_ff;
                     scan_in  = '0;
                     state_in = S_TAKE_RD;
                  end
               end
               ocl_pkg::CMD_LOAD: begin
                  if ((fill_ext + CW'(ocl_pkg::DECK_SIZE)) > CW'(DEPTH)) begin
                     rep_status_in = ocl_pkg::STATUS_FULL;
                  end else begin
                     rank_in  = '0;
                     suit_in  = '0;
                     state_in = S_LOAD;
                  end
               end
               default: begin
                  rep_status_in = ocl_pkg::STATUS_NOT_FOUND;
               end
            endcase
         end

         // Linear search: one read issued and one card compared per cycle.
         S_SEARCH: begin
            if (search_hit) begin
               rep_fpos_in = hit_pos[ocl_pkg::FPOS_W-1:0];
               state_in    = S_REPLY;
            end else if (scan_ff < fill_ff) begin
               mem_rd_en = 1'b1;
               rd_vld_in = 1'b1;
               scan_in   = scan_ff + FW'(1);
            end else begin
               rep_status_in = ocl_pkg::STATUS_NOT_FOUND;
               state_in      = S_REPLY;
            end
         end

         // Capture the card read at the resolved position.
         S_READ: begin
            rep_card_in = mem_rd_data;
            state_in    = S_REPLY;
         end

         // Move cards down by the offset: read the source, write it in the following cycle.
         S_SHIFT: begin
            if (rd_vld_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wr_addr_ff;
               mem_wr_data = mem_rd_data;
            end
            if (scan_ff < end_ff) begin
               mem_rd_en  = 1'b1;
               rd_vld_in  = 1'b1;
               wr_addr_in = AW'(scan_ff - off_ff);
               scan_in    = scan_ff + FW'(1);
            end else begin
               rd_vld_in = 1'b0;
               state_in  = (cmd_ff == ocl_pkg::CMD_REMOVE) ? S_REPLY : S_IDLE;
            end
         end

         // Take front: read the next card from the front.
         S_TAKE_RD: begin
            mem_rd_en = 1'b1;
            state_in  = S_TAKE_WAIT;
         end

         // Take front: hand the card to the output register when it is free.
         S_TAKE_WAIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ocl_pkg::STATUS_OK;
               rsp_card_in   = mem_rd_data;
               rsp_fpos_in   = '0;
               rsp_held_in   = fill_ext[ocl_pkg::HELD_W-1:0];
               rsp_last_in   = take_last;
               if (take_last) begin
                  scan_in   = FW'(n_ext);
                  off_in    = FW'(n_ext);
                  rd_vld_in = 1'b0;
                  state_in  = S_SHIFT;
               end else begin
                  scan_in  = scan_ff + FW'(1);
                  state_in = S_TAKE_RD;
               end
            end
         end

         // Load a deck in suit-major order, one card per cycle.
         S_LOAD: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = '{suit: suit_ff, value: rank_ff};
            fill_in     = fill_ff + FW'(1);
            if (rank_ff == ocl_pkg::VALUE_W'(ocl_pkg::NUM_RANKS - 1)) begin
               rank_in = '0;
               if (suit_ff == ocl_pkg::SUIT_W'(ocl_pkg::NUM_SUITS - 1)) begin
                  state_in = S_REPLY;
               end else begin
                  suit_in = suit_ff + ocl_pkg::SUIT_W'(1);
               end
            end else begin
               rank_in = rank_ff + ocl_pkg::VALUE_W'(1);
            end
         end

         // Deliver the single response of the command.
         S_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = rep_status_ff;
               rsp_card_in   = rep_card_ff;
               rsp_fpos_in   = rep_fpos_ff;
               rsp_held_in   = fill_ext[ocl_pkg::HELD_W-1:0];
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      card_ff       <= card_in;
      pos_ff        <= pos_in;
      count_ff      <= count_in;
      scan_ff       <= scan_in;
      end_ff        <= end_in;
      off_ff        <= off_in;
      wr_addr_ff    <= wr_addr_in;
      rank_ff       <= rank_in;
      suit_ff       <= suit_in;
      rep_status_ff <= rep_status_in;
      rep_card_ff   <= rep_card_in;
      rep_fpos_ff   <= rep_fpos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_card_ff   <= rsp_card_in;
      rsp_fpos_ff   <= rsp_fpos_in;
      rsp_held_ff   <= rsp_held_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Response channel outputs.
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.out_value      = rsp_card_ff.value;
   assign rsp_if.out_suit       = rsp_card_ff.suit;
   assign rsp_if.found_position = rsp_fpos_ff;
   assign rsp_if.held_count     = rsp_held_ff;
   assign rsp_if.last           = rsp_last_ff;

   // The fill count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(DEPTH))
      else $error("fill count above capacity");

   // An append with room grows the list by exactly one card.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_if.cmd == ocl_pkg::CMD_APPEND) && (fill_ff < FW'(DEPTH)))
      |=> ##1 (fill_ff == $past(fill_ff, 2) + FW'(1)))
      else $error("append did not add one card");

   // A response without the last mark only comes while take front is still delivering.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.last) |-> (state_ff == S_TAKE_RD || state_ff == S_TAKE_WAIT))
      else $error("non-final response outside take front");

   // The card memory is written only by commands that change the list.
   assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == S_EXEC || state_ff == S_LOAD || state_ff == S_SHIFT))
      else $error("card memory written in an unexpected state");

endmodule
